// File: design/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

    // Field widths fixed by the pixel format
    localparam int IN_W = 13;
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Hue sector size in whole degrees
    localparam int SECT_DEG = 60;

    // q / 60 as (q * 8739) >> 19, exact for q below 10082
    localparam int DIV60_MUL   = 8739;
    localparam int DIV60_MUL_W = 14;
    localparam int DIV60_SHIFT = 19;

    // k / 6 as (k * 171) >> 10, exact for k below 512
    localparam int DIV6_MUL   = 171;
    localparam int DIV6_W     = 16;
    localparam int DIV6_SHIFT = 10;
    localparam int DIV6_Q_W   = 5;

    // Whole-degree quotient by 60 of a 13-bit value is at most 136
    localparam int K_W = 8;
    // Remainder of whole degrees modulo 60
    localparam int RMOD_W = 6;

    // Channel scale: 255 over the unit, and 255/60 reduced to 17/4
    localparam int CH_SCALE = 255;
    localparam int X_SCALE  = 17;
    localparam int X_SCALE_W = 5;

    typedef enum logic [2:0] {
        SECT_000_060 = 3'd0,
        SECT_060_120 = 3'd1,
        SECT_120_180 = 3'd2,
        SECT_180_240 = 3'd3,
        SECT_240_300 = 3'd4,
        SECT_300_360 = 3'd5
    } t_sector;

endpackage

`default_nettype wire

// File: design/hsl_to_rgb_converter.sv
// HSL to RGB pixel converter.
// Input channel: i_in_valid / o_in_ready carry one pixel per transaction on
// i_hue (1/2^HUE_FRAC_BITS degree), i_saturation and i_lightness (unsigned,
// 2^UNIT_FRAC_BITS is 1.0). Output channel: o_out_valid / i_out_ready carry
// o_red, o_green, o_blue, each floor((component + offset) * 255).
// Hue at or beyond 360 degrees wraps; saturation or lightness above 1.0
// are taken as 1.0.
// Six register stages (clamp and hue/60, chroma multiply, offset, secondary
// multiply, scaling, sector select into the output register) lie between the
// accepting edge and o_out_valid. Throughput: one pixel per cycle while the
// receiver does not stall; each stage holds one pixel.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it keep filling until every stage is occupied; only then
// does o_in_ready drop. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties every stage; o_out_valid falls
// and o_in_ready is high in the first cycle after reset.
`default_nettype none

module hsl_to_rgb_converter #(
    parameter int UNIT_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS  = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]  i_hue,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]  i_saturation,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]  i_lightness,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_red,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_green,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_blue
);

    import hsl2rgb_pkg::*;

    localparam int NS       = 6;
    localparam int UW       = UNIT_FRAC_BITS + 1;          // holds 1.0
    localparam int EW       = (UW > IN_W) ? UW : IN_W;
    localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;
    localparam int RW       = 6 + HUE_FRAC_BITS;           // hue within a sector, up to H60
    localparam int H60      = SECT_DEG << HUE_FRAC_BITS;
    localparam int LO_MASK  = (1 << HUE_FRAC_BITS) - 1;
    localparam int KPW      = IN_W + DIV60_MUL_W;
    localparam int CW       = 2 * UW - 1;                  // chroma, up to U^2
    localparam int AW       = 2 * UW;                      // 2*l*U - c, up to 2*U^2
    localparam int PW       = CW + RW;
    localparam int V0W      = AW + 8;
    localparam int VCW      = AW + 9;
    localparam int VXW      = AW + RW + 1;
    localparam int VXSW     = VXW + X_SCALE_W;
    localparam int SH_C     = 2 * UNIT_FRAC_BITS + 1;
    localparam int SH_X     = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 3;

    // stage valid bits and per-stage advance
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[NS-1];

    // ---------------- stage 1: clamp, lightness distance, whole degrees / 60
    logic [EW-1:0]   sat_ext;
    logic [EW-1:0]   lit_ext;
    logic [UW-1:0]   sat_c;
    logic [UW-1:0]   lit_c;
    logic [UW:0]     twol;
    logic [UW:0]     ldev;
    logic [IN_W-1:0] q1;
    logic [KPW-1:0]  kprod;

    logic [UW-1:0]   r_s1_sat;
    logic [UW-1:0]   r_s1_lit;
    logic [UW-1:0]   r_s1_ud;
    logic [IN_W-1:0] r_s1_hue;
    logic [K_W-1:0]  r_s1_k;

    always_comb begin
        sat_ext = EW'(i_saturation);
        lit_ext = EW'(i_lightness);
        sat_c   = (sat_ext > EW'(UNIT_ONE)) ? UW'(UNIT_ONE) : UW'(sat_ext);
        lit_c   = (lit_ext > EW'(UNIT_ONE)) ? UW'(UNIT_ONE) : UW'(lit_ext);
        twol    = {lit_c, 1'b0};
        ldev    = (twol >= (UW+1)'(UNIT_ONE)) ? (twol - (UW+1)'(UNIT_ONE))
                                              : ((UW+1)'(UNIT_ONE) - twol);
        q1      = i_hue >> HUE_FRAC_BITS;
        kprod   = KPW'(q1) * KPW'(DIV60_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_sat <= sat_c;
            r_s1_lit <= lit_c;
            r_s1_ud  <= UW'(UNIT_ONE) - UW'(ldev);
            r_s1_hue <= i_hue;
            r_s1_k   <= kprod[DIV60_SHIFT +: K_W];
        end
    end

    // ---------------- stage 2: chroma, hue within sector, sector number
    logic [IN_W-1:0]   q2;
    logic [IN_W-1:0]   rmod_full;
    logic [IN_W-1:0]   hue_lo;
    logic [DIV6_W-1:0] kd6prod;
    logic [K_W-1:0]    sect_full;

    logic [CW-1:0]     r_s2_cn;
    logic [UW-1:0]     r_s2_lit;
    logic [RW-1:0]     r_s2_r;
    logic              r_s2_odd;
    t_sector           r_s2_sector;

    always_comb begin
        q2        = r_s1_hue >> HUE_FRAC_BITS;
        rmod_full = q2 - IN_W'(r_s1_k) * IN_W'(SECT_DEG);
        hue_lo    = r_s1_hue & IN_W'(LO_MASK);
        kd6prod   = DIV6_W'(r_s1_k) * DIV6_W'(DIV6_MUL);
        // k mod 6 picks the sector, so hue wraps at 360 degrees for free
        sect_full = r_s1_k - K_W'(kd6prod[DIV6_SHIFT +: DIV6_Q_W]) * K_W'(6);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_cn     <= CW'(AW'(r_s1_ud) * AW'(r_s1_sat));
            r_s2_lit    <= r_s1_lit;
            r_s2_r      <= (RW'(rmod_full[RMOD_W-1:0]) << HUE_FRAC_BITS) | RW'(hue_lo);
            r_s2_odd    <= r_s1_k[0];
            r_s2_sector <= t_sector'(sect_full[2:0]);
        end
    end

    // ---------------- stage 3: offset term and secondary weight
    logic [CW-1:0] r_s3_cn;
    logic [AW-1:0] r_s3_a;
    logic [RW-1:0] r_s3_y;
    t_sector       r_s3_sector;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_cn     <= r_s2_cn;
            r_s3_a      <= (AW'(r_s2_lit) << (UNIT_FRAC_BITS + 1)) - AW'(r_s2_cn);
            // odd sectors fall from the peak, even ones rise to it
            r_s3_y      <= r_s2_odd ? (RW'(H60) - r_s2_r) : r_s2_r;
            r_s3_sector <= r_s2_sector;
        end
    end

    // ---------------- stage 4: secondary product
    logic [PW-1:0] r_s4_px;
    logic [CW-1:0] r_s4_cn;
    logic [AW-1:0] r_s4_a;
    t_sector       r_s4_sector;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_px     <= PW'(r_s3_cn) * PW'(r_s3_y);
            r_s4_cn     <= r_s3_cn;
            r_s4_a      <= r_s3_a;
            r_s4_sector <= r_s3_sector;
        end
    end

    // ---------------- stage 5: scale to 255
    logic [VCW-1:0] vc_sum;

    logic [V0W-1:0] r_s5_v0;
    logic [VCW-1:0] r_s5_vc;
    logic [VXW-1:0] r_s5_vx;
    t_sector        r_s5_sector;

    assign vc_sum = VCW'({r_s4_cn, 1'b0}) + VCW'(r_s4_a);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_v0     <= V0W'(r_s4_a) * V0W'(CH_SCALE);
            r_s5_vc     <= vc_sum * VCW'(CH_SCALE);
            r_s5_vx     <= VXW'({r_s4_px, 1'b0}) + VXW'(r_s4_a) * VXW'(H60);
            r_s5_sector <= r_s4_sector;
        end
    end

    // ---------------- stage 6: truncate, clamp, place by sector
    logic [V0W-1:0]  c0_sh;
    logic [VCW-1:0]  cc_sh;
    logic [VXSW-1:0] cx_sh;
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] chc;
    logic [CH_W-1:0] chx;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;

    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    always_comb begin
        c0_sh = r_s5_v0 >> SH_C;
        cc_sh = r_s5_vc >> SH_C;
        cx_sh = (VXSW'(r_s5_vx) * VXSW'(X_SCALE)) >> SH_X;
        ch0   = (|c0_sh[V0W-1:CH_W])  ? CH_MAX : c0_sh[CH_W-1:0];
        chc   = (|cc_sh[VCW-1:CH_W])  ? CH_MAX : cc_sh[CH_W-1:0];
        chx   = (|cx_sh[VXSW-1:CH_W]) ? CH_MAX : cx_sh[CH_W-1:0];
        case (r_s5_sector)
            SECT_000_060: begin
                n_red = chc; n_green = chx; n_blue = ch0;
            end
            SECT_060_120: begin
                n_red = chx; n_green = chc; n_blue = ch0;
            end
            SECT_120_180: begin
                n_red = ch0; n_green = chc; n_blue = chx;
            end
            SECT_180_240: begin
                n_red = ch0; n_green = chx; n_blue = chc;
            end
            SECT_240_300: begin
                n_red = chx; n_green = ch0; n_blue = chc;
            end
            default: begin
                // 300 to 360 degrees
                n_red = chc; n_green = ch0; n_blue = chx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

`ifndef NO_ASSERTIONS
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction did not reach stage 1");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while every stage is full and stalled");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_s1_sat <= UW'(UNIT_ONE) && r_s1_lit <= UW'(UNIT_ONE)))
        else $error("saturation or lightness above unity after clamp");

    a_hue_in_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_r < RW'(H60)))
        else $error("hue within sector out of range");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_sector <= SECT_300_360))
        else $error("sector number out of range");
`endif

endmodule

`default_nettype wire
